// ===== hw/rtl/rtc_pkg.sv =====
// Package for the clock/calendar with alarm.
// Holds command codes, the item struct, field limits, month lengths and the leap test.
// No dependencies.
`default_nettype none

package rtc_pkg;

    localparam int unsigned YEAR_W       = 14;
    localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(9999);

    localparam logic [3:0] TENTH_MAX = 4'd9;
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd11;
    localparam logic [4:0] DAY_FIRST = 5'd1;

    // Divisibility by 25 via the modular inverse of 25 mod 2**YEAR_W.
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_SET_TIME    = 3'd1,
        CMD_SET_DATE    = 3'd2,
        CMD_SET_ALARM   = 3'd3,
        CMD_CLEAR_ALARM = 3'd4
    } cmd_t;

    typedef struct packed {
        logic              go;
        cmd_t              cmd;
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic              year_leap;
    } item_t;

    typedef struct packed {
        logic time_ok;
        logic fired;
    } time_stat_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
        div25 = prod[YEAR_W-1:0] <= DIV25_MAX;
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtc_time.sv =====
// Time-of-day counters (tenths to hours) and the one-shot alarm.
// Depends on rtc_pkg; feeds the day carry to rtc_date.
`default_nettype none

module rtc_time (
    input  logic               aclk,
    input  logic               aresetn,
    input  rtc_pkg::item_t     item,
    output logic               day_carry,
    output rtc_pkg::time_stat_t stat,
    output logic [3:0]         tenth,
    output logic [5:0]         sec,
    output logic [5:0]         min,
    output logic [4:0]         hour,
    output logic               alarm_armed
);
    import rtc_pkg::*;

    logic [3:0] tenth_reg, tenth_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic       alarm_reg, alarm_next;
    logic [5:0] a_sec_reg, a_sec_next;
    logic [5:0] a_min_reg, a_min_next;
    logic [4:0] a_hour_reg, a_hour_next;

    logic       t_wrap, s_wrap, m_wrap, h_wrap;
    logic [3:0] tick_tenth;
    logic [5:0] tick_sec, tick_min;
    logic [4:0] tick_hour;
    logic       time_ok, fired;
    logic [6:0] sum_sec, sum_min;
    logic [5:0] sum_hour;
    logic       c_sec, c_min;
    logic [5:0] off_sec, off_min;
    logic [4:0] off_hour;

    always_comb begin
        t_wrap     = tenth_reg == TENTH_MAX;
        s_wrap     = t_wrap && (sec_reg == SEC_MAX);
        m_wrap     = s_wrap && (min_reg == MIN_MAX);
        h_wrap     = m_wrap && (hour_reg == HOUR_MAX);
        tick_tenth = t_wrap ? 4'd0 : tenth_reg + 4'd1;
        tick_sec   = t_wrap ? (s_wrap ? 6'd0 : sec_reg + 6'd1) : sec_reg;
        tick_min   = s_wrap ? (m_wrap ? 6'd0 : min_reg + 6'd1) : min_reg;
        tick_hour  = m_wrap ? (h_wrap ? 5'd0 : hour_reg + 5'd1) : hour_reg;
        fired      = alarm_reg && (tick_sec == a_sec_reg) && (tick_min == a_min_reg)
                     && (tick_hour == a_hour_reg);

        time_ok = (item.sec <= SEC_MAX) && (item.min <= MIN_MAX) && (item.hour <= HOUR_MAX);

        sum_sec  = {1'b0, sec_reg} + {1'b0, item.sec};
        c_sec    = sum_sec > 7'd59;
        off_sec  = c_sec ? 6'(sum_sec - 7'd60) : sum_sec[5:0];
        sum_min  = {1'b0, min_reg} + {1'b0, item.min} + {6'd0, c_sec};
        c_min    = sum_min > 7'd59;
        off_min  = c_min ? 6'(sum_min - 7'd60) : sum_min[5:0];
        sum_hour = {1'b0, hour_reg} + {1'b0, item.hour} + {5'd0, c_min};
        off_hour = (sum_hour > 6'd23) ? 5'(sum_hour - 6'd24) : sum_hour[4:0];
    end

    always_comb begin
        tenth_next  = tenth_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        alarm_next  = alarm_reg;
        a_sec_next  = a_sec_reg;
        a_min_next  = a_min_reg;
        a_hour_next = a_hour_reg;
        if (item.go) begin
            case (item.cmd)
                CMD_TICK: begin
                    tenth_next = tick_tenth;
                    sec_next   = tick_sec;
                    min_next   = tick_min;
                    hour_next  = tick_hour;
                    if (fired) begin
                        alarm_next = 1'b0;
                    end
                end
                CMD_SET_TIME: begin
                    if (time_ok) begin
                        tenth_next = 4'd0;
                        sec_next   = item.sec;
                        min_next   = item.min;
                        hour_next  = item.hour;
                    end
                end
                CMD_SET_ALARM: begin
                    if (time_ok) begin
                        a_sec_next  = off_sec;
                        a_min_next  = off_min;
                        a_hour_next = off_hour;
                        alarm_next  = 1'b1;
                    end
                end
                CMD_CLEAR_ALARM: begin
                    alarm_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tenth_reg  <= '0;
            sec_reg    <= '0;
            min_reg    <= '0;
            hour_reg   <= '0;
            alarm_reg  <= 1'b0;
            a_sec_reg  <= '0;
            a_min_reg  <= '0;
            a_hour_reg <= '0;
        end else begin
            tenth_reg  <= tenth_next;
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hour_reg   <= hour_next;
            alarm_reg  <= alarm_next;
            a_sec_reg  <= a_sec_next;
            a_min_reg  <= a_min_next;
            a_hour_reg <= a_hour_next;
        end
    end

    assign day_carry     = item.go && (item.cmd == CMD_TICK) && h_wrap;
    assign stat.time_ok  = time_ok;
    assign stat.fired    = fired;
    assign tenth         = tenth_reg;
    assign sec           = sec_reg;
    assign min           = min_reg;
    assign hour          = hour_reg;
    assign alarm_armed   = alarm_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtc_date.sv =====
// Calendar counters (day, month, year) and the leap flag.
// Depends on rtc_pkg; advanced by the day carry from rtc_time.
`default_nettype none

module rtc_date (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rtc_pkg::item_t            item,
    input  logic                      day_carry,
    output logic                      date_ok,
    output logic [4:0]                day,
    output logic [3:0]                month,
    output logic [rtc_pkg::YEAR_W-1:0] year
);
    import rtc_pkg::*;

    logic [4:0]        day_reg, day_next;
    logic [3:0]        month_reg, month_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic              leap_reg, leap_next;

    logic              d_wrap, mo_wrap;
    logic [YEAR_W-1:0] year_inc;

    always_comb begin
        d_wrap   = day_reg >= month_days(month_reg, leap_reg);
        mo_wrap  = month_reg >= MONTH_MAX;
        year_inc = (year_reg >= YEAR_LIMIT) ? '0 : year_reg + YEAR_W'(1);
        date_ok  = (item.year <= YEAR_LIMIT) && (item.month <= MONTH_MAX)
                   && (item.day != 5'd0)
                   && (item.day <= month_days(item.month, item.year_leap));
    end

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        if (day_carry) begin
            day_next = d_wrap ? DAY_FIRST : day_reg + 5'd1;
            if (d_wrap) begin
                month_next = mo_wrap ? 4'd0 : month_reg + 4'd1;
                if (mo_wrap) begin
                    year_next = year_inc;
                    leap_next = is_leap(year_inc);
                end
            end
        end else if (item.go && (item.cmd == CMD_SET_DATE) && date_ok) begin
            day_next   = item.day;
            month_next = item.month;
            year_next  = item.year;
            leap_next  = item.year_leap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= DAY_FIRST;
            month_reg <= '0;
            year_reg  <= '0;
            leap_reg  <= 1'b0;
        end else begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            leap_reg  <= leap_next;
        end
    end

    assign day   = day_reg;
    assign month = month_reg;
    assign year  = year_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_clock_with_alarm_top.sv =====
// Throughput 1 item per cycle while m_ready does not hold the result back.
// An input register feeds the update; the clock/calendar state registers
// are the result register, with accepted and alarm-fired flags beside them.
// Synchronous active-low reset: time 00:00:00.0, day 1, month 0, year 0,
// leap flag clear, alarm disarmed, both channels empty.
`default_nettype none

module calendar_clock_with_alarm_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_command,
    input  logic [5:0]                s_in_sec,
    input  logic [5:0]                s_in_min,
    input  logic [4:0]                s_in_hour,
    input  logic [4:0]                s_in_day,
    input  logic [3:0]                s_in_month,
    input  logic [rtc_pkg::YEAR_W-1:0] s_in_year,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_accepted,
    output logic                      m_alarm_fired,
    output logic [3:0]                m_tenth_out,
    output logic [5:0]                m_sec_out,
    output logic [5:0]                m_min_out,
    output logic [4:0]                m_hour_out,
    output logic [4:0]                m_day_out,
    output logic [3:0]                m_month_out,
    output logic [rtc_pkg::YEAR_W-1:0] m_year_out,
    output logic                      m_alarm_armed
);
    import rtc_pkg::*;

    item_t      item_reg, item_next;
    logic       in_valid_reg, in_valid_next;
    logic       m_valid_reg, m_valid_next;
    logic       accepted_reg, accepted_next;
    logic       fired_reg, fired_next;
    logic       out_free, go, take;
    item_t      work;
    time_stat_t t_stat;
    logic       day_carry, date_ok;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        go       = in_valid_reg && out_free;
        s_ready  = !in_valid_reg || out_free;
        take     = s_valid && s_ready;

        item_next           = item_reg;
        item_next.go        = 1'b0;
        if (take) begin
            item_next.cmd       = cmd_t'(s_command);
            item_next.sec       = s_in_sec;
            item_next.min       = s_in_min;
            item_next.hour      = s_in_hour;
            item_next.day       = s_in_day;
            item_next.month     = s_in_month;
            item_next.year      = s_in_year;
            item_next.year_leap = is_leap(s_in_year);
        end
        in_valid_next = take ? 1'b1 : (go ? 1'b0 : in_valid_reg);

        work    = item_reg;
        work.go = go;
    end

    rtc_time u_time (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (work),
        .day_carry   (day_carry),
        .stat        (t_stat),
        .tenth       (m_tenth_out),
        .sec         (m_sec_out),
        .min         (m_min_out),
        .hour        (m_hour_out),
        .alarm_armed (m_alarm_armed)
    );

    rtc_date u_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (work),
        .day_carry (day_carry),
        .date_ok   (date_ok),
        .day       (m_day_out),
        .month     (m_month_out),
        .year      (m_year_out)
    );

    always_comb begin
        accepted_next = accepted_reg;
        fired_next    = fired_reg;
        m_valid_next  = go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        if (go) begin
            fired_next = 1'b0;
            case (item_reg.cmd)
                CMD_TICK: begin
                    accepted_next = 1'b1;
                    fired_next    = t_stat.fired;
                end
                CMD_SET_TIME:    accepted_next = t_stat.time_ok;
                CMD_SET_DATE:    accepted_next = date_ok;
                CMD_SET_ALARM:   accepted_next = t_stat.time_ok;
                CMD_CLEAR_ALARM: accepted_next = 1'b1;
                default:         accepted_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        accepted_reg <= accepted_next;
        fired_reg    <= fired_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = accepted_reg;
    assign m_alarm_fired = fired_reg;

    a_update_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> m_valid)
        else $error("update cycle did not produce a result");

    a_fired_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alarm_fired) |-> (!m_alarm_armed && m_accepted))
        else $error("alarm fired but stayed armed");

    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_tenth_out <= TENTH_MAX) && (m_sec_out <= SEC_MAX)
                     && (m_min_out <= MIN_MAX) && (m_hour_out <= HOUR_MAX)
                     && (m_day_out != 5'd0) && (m_month_out <= MONTH_MAX)
                     && (m_year_out <= YEAR_LIMIT)))
        else $error("clock or calendar field out of range");

endmodule

`default_nettype wire
